// ===== src/olde_pkg.sv =====
// ----------------------------------------------------------------------------
// olde_pkg: shared types and codes for the ordered list delete engine
// Transaction structs, command kinds, status codes and sizing defaults.
// ----------------------------------------------------------------------------
package olde_pkg;

    // default list depth and the limit on results of one dump
    localparam int OLDE_DEPTH = 16;
    localparam int MAX_RES    = 16;

    // command kinds
    localparam logic [2:0] KIND_APPEND    = 3'd0;
    localparam logic [2:0] KIND_DROP_TAIL = 3'd1;
    localparam logic [2:0] KIND_DROP_HEAD = 3'd2;
    localparam logic [2:0] KIND_DROP_VAL  = 3'd3;
    localparam logic [2:0] KIND_DROP_POS  = 3'd4;
    localparam logic [2:0] KIND_DUMP      = 3'd5;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] item_value;
        logic [3:0]         position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] entry_value;
        logic [4:0]         entry_count;
        logic               last;
    } t_out_item;

    // one result handed from the sequencer to the output register
    typedef struct packed {
        logic      push;
        t_out_item item;
    } t_res_push;

endpackage

// ===== src/olde_store.sv =====
// ----------------------------------------------------------------------------
// olde_store: entry memory of the list
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olde_store #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_wa,
    input  logic [31:0]      i_wd,
    input  logic [IDX_W-1:0] i_ra,
    output logic [31:0]      o_rd
);

    logic [31:0] mem [DEPTH];
    logic [31:0] r_rd;

    // write one entry, read one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wa] <= i_wd;
        end
        r_rd <= mem[i_ra];
    end

    assign o_rd = r_rd;

endmodule

// ===== src/olde_seq.sv =====
// ----------------------------------------------------------------------------
// olde_seq: command sequencer of the list
// Walks the entry memory one entry a cycle (a dump waits while the output
// cannot take a result) with an equality compare and index incrementers to search, close gaps and dump.
// ----------------------------------------------------------------------------
module olde_seq #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  olde_pkg::t_in_item i_in_item,
    input  logic              i_can_push,
    output logic              o_busy,
    output olde_pkg::t_res_push o_res,
    output logic              o_we,
    output logic [IDX_W-1:0]  o_wa,
    output logic [31:0]       o_wd,
    output logic [IDX_W-1:0]  o_ra,
    input  logic [31:0]       i_rd,
    output logic [CNT_W-1:0]  o_fill
);
    import olde_pkg::*;

    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int W     = CMP_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SHIFT,
        S_DUMP,
        S_RESULT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_value, n_value;
    logic [1:0]       r_status, n_status;

    logic [W-1:0] w_fill_x, w_idx_x, w_idx1, w_idx2, w_pos_x, w_pos1, w_dump_n, w_ra;
    logic         w_empty;

    // widen counters and indexes to one compare width
    assign w_fill_x = {{(W-CNT_W){1'b0}}, r_fill};
    assign w_idx_x  = {{(W-IDX_W){1'b0}}, r_idx};
    assign w_idx1   = w_idx_x + W'(1);
    assign w_idx2   = w_idx_x + W'(2);
    assign w_pos_x  = {{(W-4){1'b0}}, i_in_item.position};
    assign w_pos1   = w_pos_x + W'(1);
    assign w_dump_n = (w_fill_x < W'(MAX_RES)) ? w_fill_x : W'(MAX_RES);
    assign w_empty  = (r_fill == '0);

    // next state, memory port and result
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_value  = r_value;
        n_status = r_status;
        o_we     = 1'b0;
        o_wa     = r_idx;
        o_wd     = i_rd;
        w_ra     = w_idx_x;
        o_res.push             = 1'b0;
        o_res.item.status      = r_status;
        o_res.item.entry_value = '0;
        o_res.item.entry_count = w_fill_x[4:0];
        o_res.item.last        = 1'b1;

        case (r_state)
            S_IDLE: begin
                w_ra = '0;
                if (i_in_valid) begin
                    n_state  = S_RESULT;
                    n_status = ST_DONE;
                    case (i_in_item.kind)
                        KIND_APPEND: begin
                            if (w_fill_x == W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we   = 1'b1;
                                o_wa   = w_fill_x[IDX_W-1:0];
                                o_wd   = i_in_item.item_value;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        KIND_DROP_TAIL: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_fill = r_fill - 1'b1;
                            end
                        end
                        KIND_DROP_HEAD: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if (w_fill_x == W'(1)) begin
                                n_fill = r_fill - 1'b1;
                            end else begin
                                n_idx   = '0;
                                w_ra    = W'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        KIND_DROP_VAL: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_value = i_in_item.item_value;
                                n_state = S_SRCH;
                            end
                        end
                        KIND_DROP_POS: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else if (w_pos_x >= w_fill_x) begin
                                n_status = ST_MISS;
                            end else if (w_pos1 == w_fill_x) begin
                                n_fill = r_fill - 1'b1;
                            end else begin
                                n_idx   = w_pos_x[IDX_W-1:0];
                                w_ra    = w_pos1;
                                n_state = S_SHIFT;
                            end
                        end
                        KIND_DUMP: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                // fetch the following entry: next to compare, or first to move
                w_ra = w_idx1;
                if (i_rd == r_value) begin
                    n_status = ST_DONE;
                    if (w_idx1 == w_fill_x) begin
                        n_fill  = r_fill - 1'b1;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (w_idx1 == w_fill_x) begin
                    n_status = ST_MISS;
                    n_state  = S_RESULT;
                end else begin
                    n_idx = w_idx1[IDX_W-1:0];
                end
            end
            S_SHIFT: begin
                // move the entry after the gap one place towards the head
                o_we = 1'b1;
                o_wa = r_idx;
                o_wd = i_rd;
                w_ra = w_idx2;
                if (w_idx2 == w_fill_x) begin
                    n_fill   = r_fill - 1'b1;
                    n_status = ST_DONE;
                    n_state  = S_RESULT;
                end else begin
                    n_idx = w_idx1[IDX_W-1:0];
                end
            end
            S_DUMP: begin
                if (i_can_push) begin
                    o_res.push             = 1'b1;
                    o_res.item.status      = ST_DONE;
                    o_res.item.entry_value = i_rd;
                    o_res.item.last        = (w_idx1 == w_dump_n);
                    w_ra                   = w_idx1;
                    if (w_idx1 == w_dump_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = w_idx1[IDX_W-1:0];
                    end
                end else begin
                    // hold the current entry on the read port
                    w_ra = w_idx_x;
                end
            end
            S_RESULT: begin
                if (i_can_push) begin
                    o_res.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ra   = w_ra[IDX_W-1:0];
    assign o_busy = (r_state != S_IDLE);
    assign o_fill = r_fill;

    // hold state and count; working registers need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
        r_idx    <= n_idx;
        r_value  <= n_value;
        r_status <= n_status;
    end

endmodule

// ===== src/ordered_list_delete_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_delete_engine: bounded ordered list with removal commands
// Append, drop tail, drop head, drop by value, drop at position and dump
// over a list of up to DEPTH signed 32-bit entries kept in insertion order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
//  Append, drop tail and unknown kinds go from accept straight to the result.
//  Drop by value compares one entry a cycle (up to the count), then the gap
//  closes one entry a cycle, then the result is given; the single read port of
//  the entry memory sets that pace. Dump gives one entry a cycle unless the output stalls.
//  Reset clears the count, state and output valid; no clearing pass over the memory.
//  A stalled output holds the sequencer; the input is stalled while busy.
// ----------------------------------------------------------------------------
module ordered_list_delete_engine #(
    parameter int DEPTH = olde_pkg::OLDE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  olde_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output olde_pkg::t_out_item o_out_item
);
    import olde_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             w_busy, w_can_push, w_we, w_in_acc;
    logic [IDX_W-1:0] w_wa, w_ra;
    logic [31:0]      w_wd, w_rd;
    logic [CNT_W-1:0] w_fill;
    t_res_push        w_res;
    logic             r_out_valid;
    t_out_item        r_out_item;

    assign w_can_push = !r_out_valid || !i_out_stall;
    assign w_in_acc   = i_in_valid && !w_busy;

    olde_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_can_push (w_can_push),
        .o_busy     (w_busy),
        .o_res      (w_res),
        .o_we       (w_we),
        .o_wa       (w_wa),
        .o_wd       (w_wd),
        .o_ra       (w_ra),
        .i_rd       (w_rd),
        .o_fill     (w_fill)
    );

    olde_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk (i_clk),
        .i_we  (w_we),
        .i_wa  (w_wa),
        .i_wd  (w_wd),
        .i_ra  (w_ra),
        .o_rd  (w_rd)
    );

    // hold a result until the transaction completes, load the next one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_res.push) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // an accepted command always makes the sequencer busy in the next cycle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after an accepted transaction");

    // an append to a list with room grows the count by one
    a_append_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_item.kind == KIND_APPEND) && (w_fill != CNT_W'(DEPTH)))
        |=> (w_fill == $past(w_fill) + 1'b1))
        else $error("append did not grow the count");

    // reset empties the list
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_fill == '0) && !o_out_valid)
        else $error("list not empty after reset");

endmodule

// ===== test/tb_ordered_list_delete_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_delete_engine: self-checking bench for the ordered list
// Sends list commands through the valid/stall input channel and keeps its own
// copy of the list to work out every reply. Replies are checked field by field
// against the oldest awaited one. The sender idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_ordered_list_delete_engine;
    import olde_pkg::*;

    localparam int LIST_DEPTH     = OLDE_DEPTH;
    localparam int END_LINGER     = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CMDS    = 250;
    localparam int SEGMENT_LEN    = 20;

    // kind codes the block treats as no operation
    localparam logic [2:0] KIND_UNUSED_A = 3'd6;
    localparam logic [2:0] KIND_UNUSED_B = 3'd7;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    // bench copy of the list and the replies still to come
    logic signed [31:0] list_model[$];
    t_out_item          awaited_replies[$];

    int unsigned error_count;
    int unsigned reply_index;
    int unsigned idle_cycles;
    bit          steady_sender;
    int unsigned stall_left;
    int unsigned calm_left;

    ordered_list_delete_engine #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // print one mismatch and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at reply %0d: %s got %0d, expected %0d",
                 reply_index, what, got, want);
        error_count++;
    endtask

    // queue one awaited reply
    function automatic void await_reply(input logic [1:0] st, input logic signed [31:0] value,
                                        input bit is_last);
        t_out_item res;
        res.status      = st;
        res.entry_value = value;
        res.entry_count = 5'(list_model.size());
        res.last        = is_last;
        awaited_replies.push_back(res);
    endfunction

    // apply one accepted command to the bench list and queue its replies
    function automatic void apply_list_command(input t_in_item cmd);
        logic [1:0] st;
        int         hit;
        int         n;
        st  = ST_DONE;
        hit = -1;
        case (cmd.kind)
            KIND_APPEND: begin
                if (list_model.size() >= LIST_DEPTH) st = ST_FULL;
                else list_model.push_back(cmd.item_value);
            end
            KIND_DROP_TAIL: begin
                if (list_model.size() == 0) st = ST_EMPTY;
                else void'(list_model.pop_back());
            end
            KIND_DROP_HEAD: begin
                if (list_model.size() == 0) st = ST_EMPTY;
                else void'(list_model.pop_front());
            end
            KIND_DROP_VAL: begin
                if (list_model.size() == 0) begin
                    st = ST_EMPTY;
                end else begin
                    // first match from the head wins
                    for (int i = 0; i < list_model.size() && hit < 0; i++)
                        if (list_model[i] == cmd.item_value) hit = i;
                    if (hit < 0) st = ST_MISS;
                    else list_model.delete(hit);
                end
            end
            KIND_DROP_POS: begin
                if (list_model.size() == 0) st = ST_EMPTY;
                else if (int'(cmd.position) >= list_model.size()) st = ST_MISS;
                else list_model.delete(int'(cmd.position));
            end
            default: ;
        endcase
        if (cmd.kind == KIND_DUMP && list_model.size() != 0) begin
            n = (list_model.size() < MAX_RES) ? list_model.size() : MAX_RES;
            for (int i = 0; i < n; i++)
                await_reply(ST_DONE, list_model[i], i == n - 1);
        end else if (cmd.kind == KIND_DUMP) begin
            await_reply(ST_EMPTY, '0, 1'b1);
        end else begin
            await_reply(st, '0, 1'b1);
        end
    endfunction

    // idle length before the next command: mostly none, a few long
    function automatic int unsigned pick_send_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_sender || roll < 65) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // small pool of values so that duplicates and hits are common
    function automatic logic signed [31:0] pooled_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            5: return 32'sd2;
            6: return 32'sd3;
            default: return 32'sd100;
        endcase
    endfunction

    // send one command and wait for the transaction; called at a rising edge
    task automatic send_list_cmd(input logic [2:0] kind, input logic signed [31:0] value,
                                 input logic [3:0] pos);
        t_in_item    cmd;
        int unsigned gap;
        cmd.kind       = kind;
        cmd.item_value = value;
        cmd.position   = pos;
        gap = pick_send_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= cmd;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        apply_list_command(cmd);
    endtask

    // hold off the sender until every awaited reply has come
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_list();
        send_list_cmd(KIND_DROP_TAIL, 32'sd0, 4'd0);
        send_list_cmd(KIND_DROP_HEAD, 32'sd0, 4'd0);
        send_list_cmd(KIND_DROP_VAL, -32'sd1, 4'd0);
        send_list_cmd(KIND_DROP_POS, 32'sd0, 4'd15);
        send_list_cmd(KIND_DUMP, 32'sd0, 4'd0);
        send_list_cmd(KIND_UNUSED_A, 32'sh7fff_ffff, 4'd15);
    endtask

    task automatic test_fill_to_full();
        steady_sender = 1'b1;
        send_list_cmd(KIND_APPEND, 32'sh8000_0000, 4'd0);
        send_list_cmd(KIND_APPEND, 32'sh7fff_ffff, 4'd0);
        send_list_cmd(KIND_APPEND, 32'sd0, 4'd0);
        send_list_cmd(KIND_APPEND, -32'sd1, 4'd0);
        send_list_cmd(KIND_APPEND, 32'sd5, 4'd0);
        send_list_cmd(KIND_APPEND, 32'sd17, 4'd0);
        send_list_cmd(KIND_APPEND, 32'sd5, 4'd0);
        for (int i = 7; i < LIST_DEPTH; i++)
            send_list_cmd(KIND_APPEND, 32'(i * 1024 + i), 4'd0);
        // one more on a full list
        send_list_cmd(KIND_APPEND, 32'sd42, 4'd0);
        send_list_cmd(KIND_DUMP, 32'sd0, 4'd0);
        steady_sender = 1'b0;
    endtask

    task automatic test_removals();
        send_list_cmd(KIND_DROP_VAL, 32'sd5, 4'd0);
        send_list_cmd(KIND_DROP_VAL, 32'sd12345, 4'd0);
        send_list_cmd(KIND_DROP_POS, 32'sd0, 4'd15);
        send_list_cmd(KIND_DROP_POS, 32'sd0, 4'd0);
        send_list_cmd(KIND_DROP_POS, 32'sd0, 4'(list_model.size() - 1));
        send_list_cmd(KIND_DROP_HEAD, 32'sd0, 4'd0);
        send_list_cmd(KIND_DROP_TAIL, 32'sd0, 4'd0);
        send_list_cmd(KIND_UNUSED_B, -32'sd1, 4'd9);
        send_list_cmd(KIND_DUMP, 32'sd0, 4'd0);
        hold_until_drained();
    endtask

    // one random command, biased towards values and positions that hit
    task automatic send_random_cmd(input int unsigned append_pct);
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [3:0]         pos;
        if ($urandom_range(0, 99) < append_pct) begin
            kind = KIND_APPEND;
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2:     kind = KIND_DROP_TAIL;
                3, 4, 5:     kind = KIND_DROP_HEAD;
                6, 7, 8, 9:  kind = KIND_DROP_VAL;
                10, 11, 12:  kind = KIND_DROP_POS;
                13, 14:      kind = KIND_DUMP;
                default:     kind = ($urandom_range(0, 1) != 0) ? KIND_UNUSED_A : KIND_UNUSED_B;
            endcase
        end
        if (kind == KIND_DROP_VAL && list_model.size() != 0 && $urandom_range(0, 1) != 0)
            value = list_model[$urandom_range(0, list_model.size() - 1)];
        else if ($urandom_range(0, 2) == 0)
            value = $urandom();
        else
            value = pooled_value();
        if (list_model.size() != 0 && $urandom_range(0, 9) < 7)
            pos = 4'($urandom_range(0, list_model.size() - 1));
        else
            pos = 4'($urandom_range(0, 15));
        send_list_cmd(kind, value, pos);
    endtask

    task automatic test_random_traffic();
        int unsigned append_pct;
        append_pct = 50;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            // new fill bias and idling mode every segment
            if (n % SEGMENT_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0:       append_pct = 75;
                    1:       append_pct = 45;
                    default: append_pct = 20;
                endcase
                steady_sender = ($urandom_range(0, 4) == 0);
            end
            if (n == RANDOM_CMDS / 2) hold_until_drained();
            send_random_cmd(append_pct);
        end
        steady_sender = 1'b0;
    endtask

    // sequence of tests
    initial begin
        error_count   = 0;
        reply_index   = 0;
        steady_sender = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_fill_to_full();
        test_removals();
        test_random_traffic();
        hold_until_drained();
        repeat (END_LINGER) @(posedge i_clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // random output stall: short bursts, a few long ones, stall-free stretches
    always @(posedge i_clk) begin : out_stall_gen
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (calm_left != 0) begin
            calm_left   <= calm_left - 1;
            i_out_stall <= 1'b0;
        end else if (roll < 8) begin
            calm_left   <= $urandom_range(20, 80);
            i_out_stall <= 1'b0;
        end else if (roll < 40) begin
            stall_left  <= (roll < 37) ? $urandom_range(0, 2) : $urandom_range(10, 30);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // check each reply against the oldest awaited one
    always @(posedge i_clk) begin : reply_check
        t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("reply with none awaited, status", o_out_item.status, 0);
            end else begin
                want = awaited_replies.pop_front();
                if (o_out_item.status !== want.status)
                    report_mismatch("status", o_out_item.status, want.status);
                if (o_out_item.entry_value !== want.entry_value)
                    report_mismatch("entry_value", o_out_item.entry_value, want.entry_value);
                if (o_out_item.entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_out_item.entry_count, want.entry_count);
                if (o_out_item.last !== want.last)
                    report_mismatch("last", o_out_item.last, want.last);
            end
            reply_index++;
        end
    end

    // end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 ||
            (i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
src/olde_pkg.sv
src/olde_store.sv
src/olde_seq.sv
src/ordered_list_delete_engine.sv
test/tb_ordered_list_delete_engine.sv
